[sv/wpd_pkg.sv]
// package: types, constants and command/status structs for the wav parser
package wpd_pkg;

    localparam int unsigned MAX_CHUNKS   = 100;
    localparam int unsigned MAX_CHANNELS = 32;

    localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
    localparam logic [31:0] MAX_RATE       = 32'd384000;
    localparam logic [31:0] MAX_SAMPLES    = 32'd691200000;
    localparam logic [31:0] TAG_RIFF       = 32'h46464952;
    localparam logic [31:0] TAG_WAVE       = 32'h45564157;
    localparam logic [31:0] TAG_FMT        = 32'h20746D66;
    localparam logic [31:0] TAG_DATA       = 32'h61746164;

    typedef enum logic [3:0] {
        ST_RUNNING     = 4'd0,
        ST_DONE        = 4'd1,
        ST_TOO_SMALL   = 4'd2,
        ST_BAD_RIFF    = 4'd3,
        ST_BAD_RSIZE   = 4'd4,
        ST_BAD_WAVE    = 4'd5,
        ST_BAD_SUBSIZE = 4'd6,
        ST_BAD_FMTSIZE = 4'd7,
        ST_BAD_PARAMS  = 4'd8,
        ST_DATA_FIRST  = 4'd9,
        ST_NOT_PCM16   = 4'd10,
        ST_TOO_LARGE   = 4'd11,
        ST_NO_DATA     = 4'd12
    } status_t;

    typedef enum logic [4:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_SUBID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER,
        PH_F_TAG, PH_F_CH, PH_F_RATE, PH_F_BRATE, PH_F_ALIGN, PH_F_BITS,
        PH_SKIP, PH_DATA, PH_STOP
    } phase_t;

    typedef struct packed {
        logic div_start;
        logic [31:0] dividend_sum;
        logic [5:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [15:0] quotient;
    } div_sts_t;

endpackage

[sv/wpd_if.sv]
// valid/ready channel interfaces for the wav parser
interface wpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;
    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface wpd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic        sample_valid;
    logic signed [15:0] mono_sample;
    logic [18:0] rate_hz;
    modport source (output valid, output status, output sample_valid, output mono_sample,
                    output rate_hz, input ready);
    modport sink (input valid, input status, input sample_valid, input mono_sample,
                  input rate_hz, output ready);
endinterface

interface wpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/wpd_divider.sv]
// serial restoring divider for the channel average, truncated toward zero
module wpd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  wpd_pkg::div_cmd_t cmd,
    output wpd_pkg::div_sts_t sts
);
    import wpd_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [20:0] quo_reg, quo_next;
    logic [5:0]  rem_reg, rem_next;
    logic [5:0]  dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [20:0] mag;
    logic [6:0]  trial;
    logic [20:0] qs;

    assign mag = cmd.dividend_sum[31] ? 21'(-cmd.dividend_sum) : cmd.dividend_sum[20:0];
    assign trial = {rem_reg, quo_reg[20]};
    assign qs = neg_reg ? -quo_reg : quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (cmd.div_start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            quo_next  = mag;
            rem_next  = 6'd0;
            dvs_next  = cmd.divisor;
            neg_next  = cmd.dividend_sum[31];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 6'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[19:0], 1'b1};
            end
            else
            begin
                rem_next = trial[5:0];
                quo_next = {quo_reg[19:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd20)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.quotient = qs[15:0];

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg)) else $error("done without busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !busy_reg) else $error("divider restarted while busy");
    a_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> cmd.divisor != 6'd0) else $error("zero divisor");
`endif
endmodule

[sv/wpd_datapath.sv]
// parser datapath: byte assembly, field registers, checks and sample sum
module wpd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       file_length,
    output logic [3:0]        status,
    output logic              sample_done,
    output logic [18:0]       rate_hz,
    output wpd_pkg::div_cmd_t div_cmd
);
    import wpd_pkg::*;

    phase_t      ph_reg, ph_next, ph_c;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] fs_reg, fs_next;
    logic [2:0]  fbi_reg, fbi_next;
    logic [32:0] left_reg, left_next;
    logic        pad_reg, pad_next;
    logic [6:0]  cc_reg, cc_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [15:0] chn_reg, chn_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic [4:0]  ci_reg, ci_next;
    logic [7:0]  lo_reg, lo_next;
    logic [31:0] sum_reg, sum_next;
    logic [3:0]  st_reg, st_next;

    logic [31:0] fs_c, sum_c;
    logic [2:0]  fbi_c;
    logic [32:0] left_c;
    logic        pad_c, seen_c;
    logic [3:0]  st_c;
    logic [1:0]  k;
    logic [31:0] shifted;
    logic [31:0] v;
    logic        got2, got4;
    logic        last, early_stop;
    logic [15:0] cnt;
    logic        fire;

    assign k = fbi_reg[1:0];
    assign shifted = 32'(data_byte) << {k, 3'b000};
    assign v = ((k == 2'd0) ? 32'd0 : fs_reg) | shifted;
    assign got2 = (3'({1'b0, k}) + 3'd1) >= 3'd2;
    assign got4 = (3'({1'b0, k}) + 3'd1) >= 3'd4;
    assign last = ({1'b0, pos_reg} + 33'd1) >= {1'b0, file_length};
    assign cnt = (chn_reg == 16'd0) ? 16'd1 : chn_reg;

    always_comb
    begin
        logic [15:0] sv16;
        logic        field_done;
        sv16 = {data_byte, lo_reg};
        ph_c = ph_reg; fs_c = fs_reg; fbi_c = fbi_reg; left_c = left_reg; pad_c = pad_reg;
        cc_next = cc_reg; ftag_next = ftag_reg; chn_next = chn_reg; rate_next = rate_reg;
        bits_next = bits_reg; seen_c = seen_reg; ci_next = ci_reg; lo_next = lo_reg;
        sum_c = sum_reg; st_c = st_reg; fire = 1'b0; early_stop = 1'b0;
        field_done = 1'b0;
        case (ph_reg)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_SUBID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER,
            PH_F_RATE, PH_F_BRATE, PH_F_TAG, PH_F_CH, PH_F_ALIGN, PH_F_BITS:
            begin
                if (ph_reg == PH_RIFF && fbi_reg == 3'd0 && file_length < MIN_FILE_BYTES)
                begin
                    st_c = ST_TOO_SMALL; ph_c = PH_STOP; early_stop = 1'b1;
                end
                else if (ph_reg == PH_SUBID && fbi_reg == 3'd0 && cc_reg >= 7'(MAX_CHUNKS))
                begin
                    st_c = ST_NO_DATA; ph_c = PH_STOP; early_stop = 1'b1;
                end
                if (!early_stop)
                begin
                    if (ph_reg == PH_SUBID && fbi_reg == 3'd0)
                        cc_next = cc_reg + 7'd1;
                    fs_c = v;
                    field_done = (ph_reg inside {PH_F_TAG, PH_F_CH, PH_F_ALIGN, PH_F_BITS})
                                 ? got2 : got4;
                    fbi_c = field_done ? 3'd0 : 3'({1'b0, k}) + 3'd1;
                end
                if (field_done)
                begin
                    case (ph_reg)
                        PH_RIFF:
                            if (v != TAG_RIFF) begin st_c = ST_BAD_RIFF; ph_c = PH_STOP; end
                            else ph_c = PH_RSIZE;
                        PH_RSIZE:
                            if ({1'b0, v} + 33'd8 > {1'b0, file_length})
                            begin st_c = ST_BAD_RSIZE; ph_c = PH_STOP; end
                            else ph_c = PH_WAVE;
                        PH_WAVE:
                            if (v != TAG_WAVE) begin st_c = ST_BAD_WAVE; ph_c = PH_STOP; end
                            else ph_c = PH_SUBID;
                        PH_SUBID:
                            ph_c = (v == TAG_FMT) ? PH_SZ_FMT :
                                   (v == TAG_DATA) ? PH_SZ_DATA : PH_SZ_OTHER;
                        PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER:
                        begin
                            if ({1'b0, pos_reg} + 33'd1 + {1'b0, v} > {1'b0, file_length})
                            begin st_c = ST_BAD_SUBSIZE; ph_c = PH_STOP; end
                            else if (ph_reg == PH_SZ_FMT)
                            begin
                                if (v < 32'd16) begin st_c = ST_BAD_FMTSIZE; ph_c = PH_STOP; end
                                else
                                begin
                                    left_c = {1'b0, v - 32'd16};
                                    pad_c = v[0];
                                    ph_c = PH_F_TAG;
                                end
                            end
                            else if (ph_reg == PH_SZ_DATA)
                            begin
                                if (!seen_reg) begin st_c = ST_DATA_FIRST; ph_c = PH_STOP; end
                                else if (ftag_reg != 16'd1 || bits_reg != 16'd16)
                                begin st_c = ST_NOT_PCM16; ph_c = PH_STOP; end
                                else if ((v >> 1) > MAX_SAMPLES)
                                begin st_c = ST_TOO_LARGE; ph_c = PH_STOP; end
                                else if (v == 32'd0) begin st_c = ST_DONE; ph_c = PH_STOP; end
                                else
                                begin
                                    left_c = {1'b0, v};
                                    ci_next = 5'd0; sum_c = 32'd0; ph_c = PH_DATA;
                                end
                            end
                            else
                            begin
                                left_c = {1'b0, v};
                                pad_c = v[0];
                                ph_c = (v == 32'd0 && !v[0]) ? PH_SUBID : PH_SKIP;
                            end
                        end
                        PH_F_TAG: begin ftag_next = v[15:0]; ph_c = PH_F_CH; end
                        PH_F_CH: begin chn_next = v[15:0]; ph_c = PH_F_RATE; end
                        PH_F_RATE: begin rate_next = v; ph_c = PH_F_BRATE; end
                        PH_F_BRATE: ph_c = PH_F_ALIGN;
                        PH_F_ALIGN: ph_c = PH_F_BITS;
                        default:
                        begin
                            bits_next = v[15:0];
                            if (chn_reg == 16'd0 || chn_reg > 16'(MAX_CHANNELS) ||
                                rate_reg == 32'd0 || rate_reg > MAX_RATE ||
                                v[15:0] == 16'd0 || v[15:0] > 16'd64)
                            begin st_c = ST_BAD_PARAMS; ph_c = PH_STOP; end
                            else
                            begin
                                seen_c = 1'b1;
                                ph_c = (left_reg == 33'd0 && !pad_reg) ? PH_SUBID : PH_SKIP;
                            end
                        end
                    endcase
                end
            end
            PH_SKIP:
            begin
                if (left_reg != 33'd0) left_c = left_reg - 33'd1;
                else pad_c = 1'b0;
                if (left_c == 33'd0 && !pad_c)
                begin
                    ph_c = PH_SUBID; fbi_c = 3'd0;
                end
            end
            PH_DATA:
            begin
                if (!fbi_reg[0])
                begin
                    lo_next = data_byte; fbi_c = 3'd1;
                end
                else
                begin
                    fbi_c = 3'd0;
                    sum_c = sum_reg + 32'(signed'(sv16));
                    if (32'(ci_reg) + 32'd1 >= 32'(cnt))
                    begin
                        fire = 1'b1; ci_next = 5'd0;
                    end
                    else ci_next = ci_reg + 5'd1;
                end
                left_c = left_reg - 33'd1;
                if (left_c == 33'd0) begin st_c = ST_DONE; ph_c = PH_STOP; end
            end
            default: ;
        endcase
        if (ph_c != PH_STOP && last && !early_stop)
        begin
            st_c = ST_NO_DATA; ph_c = PH_STOP;
        end
    end

    always_comb
    begin
        ph_next = ph_reg; pos_next = pos_reg; fs_next = fs_reg; fbi_next = fbi_reg;
        left_next = left_reg; pad_next = pad_reg; seen_next = seen_reg; sum_next = sum_reg;
        st_next = st_reg;
        if (clear)
        begin
            // the start byte is parsed as byte zero of the new file
            ph_next = PH_RIFF; pos_next = 32'd1; fs_next = '0; fbi_next = '0; left_next = '0;
            pad_next = 1'b0; seen_next = 1'b0; sum_next = '0; st_next = ST_RUNNING;
            if (file_length < MIN_FILE_BYTES)
            begin
                ph_next = PH_STOP; st_next = ST_TOO_SMALL;
            end
            else
            begin
                fs_next = 32'(data_byte); fbi_next = 3'd1;
            end
        end
        else if (step && ph_reg != PH_STOP)
        begin
            ph_next = ph_c; fs_next = fs_c; fbi_next = fbi_c; left_next = left_c;
            pad_next = pad_c; seen_next = seen_c; st_next = st_c;
            sum_next = fire ? 32'd0 : sum_c;
            pos_next = pos_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_RIFF; pos_reg <= '0; fs_reg <= '0; fbi_reg <= '0; left_reg <= '0;
            pad_reg <= 1'b0; cc_reg <= '0; ftag_reg <= '0; chn_reg <= '0; rate_reg <= '0;
            bits_reg <= '0; seen_reg <= 1'b0; ci_reg <= '0; lo_reg <= '0; sum_reg <= '0;
            st_reg <= ST_RUNNING;
        end
        else
        begin
            ph_reg <= ph_next; pos_reg <= pos_next; fs_reg <= fs_next; fbi_reg <= fbi_next;
            left_reg <= left_next; pad_reg <= pad_next; seen_reg <= seen_next;
            sum_reg <= sum_next; st_reg <= st_next;
            if (clear)
            begin
                cc_reg <= '0; ftag_reg <= '0; chn_reg <= '0; rate_reg <= '0; bits_reg <= '0;
                ci_reg <= '0; lo_reg <= '0;
            end
            else if (step && ph_reg != PH_STOP)
            begin
                cc_reg <= cc_next; ftag_reg <= ftag_next; chn_reg <= chn_next;
                rate_reg <= rate_next; bits_reg <= bits_next; ci_reg <= ci_next;
                lo_reg <= lo_next;
            end
        end
    end

    assign status = st_reg;
    assign sample_done = step && !clear && ph_reg != PH_STOP && fire;
    assign rate_hz = (ph_reg == PH_DATA || (ph_reg == PH_STOP &&
                     (st_reg == ST_DONE || st_reg == ST_NOT_PCM16 || st_reg == ST_TOO_LARGE)))
                     ? rate_reg[18:0] : 19'd0;
    assign div_cmd.div_start = sample_done;
    assign div_cmd.dividend_sum = sum_c;
    assign div_cmd.divisor = 6'(cnt);

`ifndef NO_ASSERTIONS
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_STOP && !clear |=> ph_reg == PH_STOP) else $error("left stop");
    a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_STOP |-> st_reg != ST_RUNNING) else $error("stop with running status");
    a_fire_data: assert property (@(posedge clk) disable iff (!rst_n)
        sample_done |-> ph_reg == PH_DATA) else $error("sample outside data");
`endif
endmodule

[sv/wpd_ctrl.sv]
// controller: input transfer, divider wait and output register handshake
module wpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              start_of_file,
    input  logic              out_ready,
    input  logic              sample_done,
    input  wpd_pkg::div_sts_t div_sts,
    output logic              in_ready,
    output logic              step,
    output logic              clear,
    output logic              out_valid,
    output logic              load_out,
    output logic              load_sample
);
    import wpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign step = in_valid && in_ready;
    assign clear = step && start_of_file;
    assign load_out = step;
    assign load_sample = (state_reg == S_DIV) && div_sts.done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (step) state_next = sample_done ? S_DIV : S_OUT;
            S_DIV:
                if (div_sts.done) state_next = S_OUT;
            S_OUT:
                if (step) state_next = sample_done ? S_DIV : S_OUT;
                else if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign out_valid = state_reg == S_OUT;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_sts.busy || div_sts.done) else $error("lost divide");
    a_no_take_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !in_ready) else $error("transfer during divide");
`endif
endmodule

[sv/wav_pcm16_parse_downmix_core.sv]
// top level: wav pcm16 parser with mono downmix
// One byte is taken per transfer and one result is returned per byte. A byte
// that completes no sample has its result shown in the cycle after it is taken;
// a byte that completes a frame goes through the serial channel divider before
// its result is shown. The result register lets the next byte be taken in the
// cycle its result is taken. file_length is written through the config channel;
// the user must write it only while idle, which the block itself does not enforce.
module wav_pcm16_parse_downmix_core (
    input logic clk,
    input logic rst_n,
    wpd_in_if.sink    in_ch,
    wpd_out_if.source out_ch,
    wpd_cfg_if.sink   cfg
);
    import wpd_pkg::*;

    logic [31:0] file_length_reg;
    logic        step, clear, sample_done, load_out, load_sample;
    logic [3:0]  status;
    logic [18:0] rate;
    div_cmd_t    div_cmd;
    div_sts_t    div_sts;
    logic [3:0]  status_reg;
    logic        sv_reg;
    logic [15:0] ms_reg;
    logic [18:0] rate_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) file_length_reg <= '0;
        else if (cfg.valid) file_length_reg <= cfg.data;
    end

    wpd_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .start_of_file(in_ch.start_of_file),
        .out_ready(out_ch.ready), .sample_done, .div_sts,
        .in_ready(in_ch.ready), .step, .clear,
        .out_valid(out_ch.valid), .load_out, .load_sample
    );

    wpd_datapath u_dp (
        .clk, .rst_n, .step, .clear, .data_byte(in_ch.data_byte),
        .file_length(file_length_reg), .status, .sample_done, .rate_hz(rate), .div_cmd
    );

    wpd_divider u_div (.clk, .rst_n, .cmd(div_cmd), .sts(div_sts));

    // result fields follow the datapath in the cycle after the transfer
    logic pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0; sv_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= load_out;
            if (load_out) sv_reg <= sample_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            status_reg <= status;
            rate_reg <= rate;
        end
        if (load_out) ms_reg <= 16'd0;
        else if (load_sample) ms_reg <= div_sts.quotient;
    end

    assign out_ch.status = pend_reg ? status : status_reg;
    assign out_ch.rate_hz = pend_reg ? rate : rate_reg;
    assign out_ch.sample_valid = sv_reg;
    assign out_ch.mono_sample = ms_reg;
endmodule
